// File: rtl/tlbns_pkg.sv
`default_nettype none

package tlbns_pkg;

  // fixed field widths
  localparam int IDX_W  = 11;
  localparam int SIZE_W = 12;

  // default geometry
  localparam int WORD_BITS_DEF = 64;
  localparam int NUM_WORDS_DEF = 32;

  // size register after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2048);

  // reciprocal division by the word width: exact for dividends below 2**DIV_IN_W
  localparam int DIV_IN_W  = 13;
  localparam int DIV_SHIFT = 20;
  localparam int RECIP_W   = 18;
  localparam int QUO_W     = DIV_IN_W + RECIP_W - DIV_SHIFT;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WORD,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] bit_pos;
  } item_t;

  typedef struct packed {
    logic             accepted;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             set_empty;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tlbns_word_mem.sv
`default_nettype none

module tlbns_word_mem #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tlbns_lsb_find.sv
`default_nettype none

module tlbns_lsb_find #(
  parameter int WIDTH = 64,
  parameter int POS_W = 6
) (
  input  logic [WIDTH-1:0] vec,
  output logic             any,
  output logic [POS_W-1:0] pos
);

  // lowest set bit wins
  always_comb begin
    any = 1'b0;
    pos = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        any = 1'b1;
        pos = POS_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/two_level_bitmap_next_set_unit.sv
`default_nettype none
// sequence: an item is taken in idle and passes check, word and done; a find that moves on to a
//   later word adds a next state, while clear or a rejected index go from check straight to done
// throughput: a new item is taken only after the last one has left done; the single-port word
//   memory sees one read, then a write-back or a second read of the word picked by the summary encoder
// reset: synchronous, clears the summary (which also marks every stored word empty) and
//   restores a size of 2048 bits; the word memory itself needs no clearing pass
module two_level_bitmap_next_set_unit
  import tlbns_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CAP_W  = $clog2(NUM_WORDS + 1);
  localparam int RECIP  = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int RESET_WORDS_RAW = (int'(SIZE_RESET) + WORD_BITS - 1) / WORD_BITS;
  localparam int RESET_WORDS = (RESET_WORDS_RAW > NUM_WORDS) ? NUM_WORDS : RESET_WORDS_RAW;

  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [IDX_W-1:0]   WB_IDX  = IDX_W'(WORD_BITS);

  // floor(x / WORD_BITS) by multiplying with a rounded-up reciprocal
  function automatic logic [QUO_W-1:0] div_word(input logic [DIV_IN_W-1:0] x);
    logic [DIV_IN_W+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, x} * {{DIV_IN_W{1'b0}}, RECIP_V};
    return prod[DIV_IN_W+RECIP_W-1:DIV_SHIFT];
  endfunction

  // ---------------------------------------------------------------- state
  state_t               state, state_next;
  op_t                  cur_op;
  logic [IDX_W-1:0]     idx;
  logic [QUO_W-1:0]     word_sel;
  logic [BIT_W-1:0]     bit_sel, bit_sel_next;
  logic [ADDR_W-1:0]    hit_word, hit_word_next;
  logic [NUM_WORDS-1:0] summary, summary_next;
  logic [CAP_W-1:0]     cap_words;
  result_t              res, res_next;

  // memory port
  logic                 mem_en, mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  // search datapath
  logic [ADDR_W-1:0]    word_addr;
  logic [WORD_BITS-1:0] cur_word, bit_onehot, masked_word, scan_word, cleared_word;
  logic [NUM_WORDS-1:0] higher;
  logic                 scan_any, higher_any, in_range, load_result;
  logic [BIT_W-1:0]     scan_pos;
  logic [ADDR_W-1:0]    higher_pos;
  logic [QUO_W-1:0]     idx_quo, cfg_quo;
  logic [NUM_WORDS-1:0] cap_mask;

  tlbns_word_mem #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // lowest set bit inside a word
  tlbns_lsb_find #(
    .WIDTH(WORD_BITS),
    .POS_W(BIT_W)
  ) u_word_find (
    .vec(scan_word),
    .any(scan_any),
    .pos(scan_pos)
  );

  // lowest non-empty word above the starting word
  tlbns_lsb_find #(
    .WIDTH(NUM_WORDS),
    .POS_W(ADDR_W)
  ) u_summary_find (
    .vec(higher),
    .any(higher_any),
    .pos(higher_pos)
  );

  // ------------------------------------------------------ index decoding
  assign idx_quo = div_word(DIV_IN_W'(item.bit_pos));
  assign cfg_quo = div_word(DIV_IN_W'(cfg_data) + DIV_IN_W'(WORD_BITS - 1));

  // the index lies inside capacity exactly when its word does
  assign in_range  = word_sel < QUO_W'(cap_words);
  assign word_addr = word_sel[ADDR_W-1:0];

  // a word whose summary bit is clear is empty, whatever the memory still holds
  assign cur_word     = mem_rdata & {WORD_BITS{summary[word_addr]}};
  assign bit_onehot   = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
  assign masked_word  = cur_word & ({WORD_BITS{1'b1}} << bit_sel);
  assign cleared_word = cur_word & ~bit_onehot;
  assign scan_word    = (state == ST_NEXT) ? mem_rdata : masked_word;
  assign higher       = summary & (({NUM_WORDS{1'b1}} << word_addr) << 1);

  assign cap_mask = ~({NUM_WORDS{1'b1}} << cap_words);

  // handshakes: input waits for the sequencer, configuration is taken whenever out of reset
  assign item_stall  = rst || (state != ST_IDLE);
  assign cfg_ready   = !rst;
  assign load_result = (state == ST_DONE) && (!result_valid || !result_stall);

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_next    = state;
    summary_next  = summary;
    res_next      = res;
    bit_sel_next  = bit_sel;
    hit_word_next = hit_word;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = word_addr;
    mem_wdata     = cur_word | bit_onehot;

    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        bit_sel_next = BIT_W'(idx - IDX_W'(word_sel * WB_IDX));
        if (cur_op == OP_CLEAR) begin
          summary_next = '0;
          res_next     = '{accepted: 1'b1, found: 1'b0, found_index: '0, set_empty: 1'b1};
          state_next   = ST_DONE;
        end else if (!in_range) begin
          res_next   = '{accepted: 1'b0, found: 1'b0, found_index: '0,
                         set_empty: (summary == '0)};
          state_next = ST_DONE;
        end else begin
          // fetch the addressed word
          mem_en     = 1'b1;
          state_next = ST_WORD;
        end
      end

      ST_WORD: begin
        state_next = ST_DONE;
        case (cur_op)
          OP_INSERT: begin
            mem_en                  = 1'b1;
            mem_we                  = 1'b1;
            mem_wdata               = cur_word | bit_onehot;
            summary_next[word_addr] = 1'b1;
            res_next = '{accepted: 1'b1, found: 1'b0, found_index: '0, set_empty: 1'b0};
          end
          OP_REMOVE: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = cleared_word;
            if (cleared_word == '0) begin
              summary_next[word_addr] = 1'b0;
            end
            res_next = '{accepted: 1'b1, found: 1'b0, found_index: '0,
                         set_empty: (summary_next == '0)};
          end
          OP_FIND: begin
            if (scan_any) begin
              // hit in the starting word
              res_next = '{accepted: 1'b1, found: 1'b1,
                           found_index: IDX_W'(word_sel * WB_IDX) + IDX_W'(scan_pos),
                           set_empty: 1'b0};
            end else if (higher_any) begin
              // second read of the next non-empty word
              mem_en        = 1'b1;
              mem_addr      = higher_pos;
              hit_word_next = higher_pos;
              state_next    = ST_NEXT;
            end else begin
              res_next = '{accepted: 1'b1, found: 1'b0, found_index: '0,
                           set_empty: (summary == '0)};
            end
          end
          default: begin
            res_next = '{accepted: 1'b1, found: 1'b0, found_index: '0,
                         set_empty: (summary == '0)};
          end
        endcase
      end

      ST_NEXT: begin
        // the word is non-empty by its summary bit, so the scan always hits
        res_next   = '{accepted: 1'b1, found: scan_any,
                       found_index: IDX_W'(IDX_W'(hit_word) * WB_IDX) + IDX_W'(scan_pos),
                       set_empty: 1'b0};
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      summary   <= '0;
      cap_words <= CAP_W'(RESET_WORDS);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        // a new size empties the set; capacity saturates at the memory depth
        summary <= '0;
        if (cfg_quo > QUO_W'(NUM_WORDS)) begin
          cap_words <= CAP_W'(NUM_WORDS);
        end else begin
          cap_words <= CAP_W'(cfg_quo);
        end
      end else begin
        summary <= summary_next;
      end
    end
  end

  // ------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      cur_op   <= item.op;
      idx      <= item.bit_pos;
      word_sel <= idx_quo;
    end
    bit_sel  <= bit_sel_next;
    hit_word <= hit_word_next;
    res      <= res_next;
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result <= res;
    end
  end

  // ---------------------------------------------------------- assertions
  a_summary_in_capacity: assert property (@(posedge clk) disable iff (rst)
    (summary & ~cap_mask) == '0)
    else $error("summary bit set beyond capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result shown without a finished item");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && cur_op == OP_CLEAR) |=> summary == '0)
    else $error("clear left words marked non-empty");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> summary == '0)
    else $error("size write did not empty the set");

  a_found_consistent: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.found) |-> (result.accepted && !result.set_empty))
    else $error("found reported on an empty or rejected search");

endmodule

`default_nettype wire

// File: dv/bitmap_result_check.sv
`default_nettype none

module bitmap_result_check
  import tlbns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  item_t             item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  result_t           result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                mismatches,
  output int                awaited
);

  localparam int WBITS  = WORD_BITS_DEF;
  localparam int NWORDS = NUM_WORDS_DEF;

  logic [WBITS-1:0]  bitmap_words [NWORDS];
  logic [NWORDS-1:0] occupied;
  logic [SIZE_W-1:0] size_bits;
  result_t           answers_due [$];
  result_t           due;

  function void empty_bitmap();
    for (int i = 0; i < NWORDS; i++) bitmap_words[i] = '0;
    occupied = '0;
  endfunction

  // applies one word to the shadow bitmap and returns the answer it should give
  function result_t apply_op(input item_t w);
    result_t          r;
    int               span_words;
    int               word_no;
    int               bit_no;
    logic [WBITS-1:0] scan;
    r          = '0;
    span_words = (int'(size_bits) + WBITS - 1) / WBITS;
    if (span_words > NWORDS) span_words = NWORDS;
    word_no = int'(w.bit_pos) / WBITS;
    bit_no  = int'(w.bit_pos) % WBITS;
    if (w.op == OP_CLEAR) begin
      empty_bitmap();
      r.accepted = 1'b1;
    end else if (int'(w.bit_pos) < span_words * WBITS) begin
      r.accepted = 1'b1;
      case (w.op)
        OP_INSERT: begin
          bitmap_words[word_no][bit_no] = 1'b1;
          occupied[word_no]             = 1'b1;
        end
        OP_REMOVE: begin
          bitmap_words[word_no][bit_no] = 1'b0;
          if (bitmap_words[word_no] == '0) occupied[word_no] = 1'b0;
        end
        OP_FIND: begin
          for (int k = word_no; k < span_words && !r.found; k++) begin
            scan = bitmap_words[k];
            // bits below the start position do not count
            if (k == word_no) scan &= {WBITS{1'b1}} << bit_no;
            for (int s = 0; s < WBITS && !r.found; s++) begin
              if (scan[s]) begin
                r.found       = 1'b1;
                r.found_index = IDX_W'(k * WBITS + s);
              end
            end
          end
        end
        default: ;
      endcase
    end
    r.set_empty = (occupied == '0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      empty_bitmap();
      size_bits = SIZE_RESET;
      answers_due.delete();
    end else begin
      // a size write empties the set
      if (cfg_valid && cfg_ready) begin
        size_bits = cfg_data;
        empty_bitmap();
      end
      if (item_valid && !item_stall) answers_due.push_back(apply_op(item));
      if (result_valid && !result_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %p", $time, result);
          mismatches++;
        end else begin
          due = answers_due.pop_front();
          if (result.accepted !== due.accepted) begin
            $display("%0t: accepted expected %0d, got %0d", $time, due.accepted,
                     result.accepted);
            mismatches++;
          end
          if (result.found !== due.found) begin
            $display("%0t: found expected %0d, got %0d", $time, due.found, result.found);
            mismatches++;
          end
          if (result.found_index !== due.found_index) begin
            $display("%0t: found_index expected %0d, got %0d", $time, due.found_index,
                     result.found_index);
            mismatches++;
          end
          if (result.set_empty !== due.set_empty) begin
            $display("%0t: set_empty expected %0d, got %0d", $time, due.set_empty,
                     result.set_empty);
            mismatches++;
          end
        end
      end
    end
    awaited = answers_due.size();
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none

module tb_top;
  import tlbns_pkg::*;

  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES = 150;
  // settling time after the last answer, covers the slowest find
  localparam int TAIL_CYCLES = 20;
  localparam int WORDS_PER_SIZE = 100;
  localparam int IDLE_PERCENT = 27;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  item_t             item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data     = '0;

  // no idling on either side while set
  logic              steady        = 1'b0;
  int                hold_requests = 0;
  int                fails;
  int                outstanding;

  always #5 clk = ~clk;

  two_level_bitmap_next_set_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  bitmap_result_check i_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (fails),
    .awaited      (outstanding)
  );

  // offer one word, with random idle cycles in front, and return once it is taken
  task automatic send_word(input op_t op, input int idx);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{op: op, bit_pos: IDX_W'(idx)};
    do @(posedge clk); while (item_stall);
  endtask

  // stop offering and wait for every outstanding answer; it always waits on the clock before it checks
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // the size may only change while the block is idle
  task automatic set_size(input int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= SIZE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int capacity_bits(input int value);
    int w;
    w = (value + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
    if (w > NUM_WORDS_DEF) w = NUM_WORDS_DEF;
    return w * WORD_BITS_DEF;
  endfunction

  // mostly in-range indices so the set fills up and finds have work to do
  task automatic random_word(input int cap);
    int   pick;
    int   idx;
    op_t  op;
    pick = $urandom_range(99);
    if (pick < 45)      op = OP_INSERT;
    else if (pick < 65) op = OP_REMOVE;
    else if (pick < 97) op = OP_FIND;
    else                op = OP_CLEAR;
    if (cap > 0 && $urandom_range(99) < 88) idx = $urandom_range(cap - 1);
    else                                    idx = $urandom_range(2047);
    send_word(op, idx);
  endtask

  // result side: random stalls, plus a long hold-off whenever one is asked for
  initial begin : receiver
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  initial begin : stimulus
    int sizes [7];
    int cap;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: default size, find on an empty set, word edges and the top bit
    send_word(OP_FIND, 0);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, 2047);
    send_word(OP_INSERT, 63);
    send_word(OP_INSERT, 64);
    send_word(OP_FIND, 0);
    send_word(OP_FIND, 1);
    send_word(OP_FIND, 65);
    send_word(OP_FIND, 2047);
    send_word(OP_REMOVE, 63);
    send_word(OP_FIND, 1);
    // word 1 goes empty, so its summary bit drops
    send_word(OP_REMOVE, 64);
    send_word(OP_FIND, 1);
    send_word(OP_REMOVE, 2047);
    send_word(OP_REMOVE, 0);
    send_word(OP_INSERT, 1000);
    send_word(OP_CLEAR, 0);
    send_word(OP_FIND, 0);

    // two words of capacity: last bit in range, first bit out of range
    set_size(65);
    send_word(OP_INSERT, 127);
    send_word(OP_INSERT, 128);
    send_word(OP_FIND, 128);
    send_word(OP_FIND, 0);

    // zero capacity rejects everything but clear
    set_size(0);
    send_word(OP_INSERT, 0);
    send_word(OP_FIND, 0);
    send_word(OP_CLEAR, 0);

    // random phases; the largest size saturates at the full word count
    sizes = '{4095, 1, 64, 2048, 130, 0, 0};
    sizes[6] = $urandom_range(4095);
    for (int p = 0; p < 7; p++) begin
      set_size(sizes[p]);
      cap = capacity_bits(sizes[p]);
      if (p == 3) steady <= 1'b1;
      for (int n = 0; n < WORDS_PER_SIZE; n++) begin
        // back up the block while words keep coming
        if (p == 1 && n == 10) hold_requests <= hold_requests + 1;
        // let everything drain mid-phase before carrying on
        if (p == 4 && n == 50) drain();
        random_word(cap);
      end
      if (p == 3) steady <= 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
